// File: design/sdu_pkg.sv
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared types for the streaming distinct-union block: the control flags that
// travel with each item from cell to cell along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sdu_pkg;

    // Width of one value in the stream.
    localparam int unsigned VALUE_W = 32;

    // Width of the distinct count carried on the output.
    localparam int unsigned OUT_CNT_W = 9;

    // Control flags that ride along with an item through the chain.
    typedef struct packed {
        logic valid;     // stage holds an item
        logic last;      // end marker: cells clear after this item passes
        logic matched;   // an earlier cell already holds this value
        logic captured;  // an earlier cell stored this value
    } item_ctrl_t;

endpackage

`default_nettype wire

// File: design/sdu_cell.sv
// ----------------------------------------------------------------------------
// sdu_cell
// One cell of the distinct store: holds one stored value and its occupied
// flag, checks each passing item against it and hands the item on.
// ----------------------------------------------------------------------------
`default_nettype none

module sdu_cell #(
    parameter int unsigned CNT_W = 9
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                advance,
    input  wire sdu_pkg::item_ctrl_t                 ctrl_in,
    input  wire logic [sdu_pkg::VALUE_W-1:0]         value_in,
    input  wire logic [CNT_W-1:0]                    count_in,
    output sdu_pkg::item_ctrl_t                      ctrl_out,
    output logic [sdu_pkg::VALUE_W-1:0]              value_out,
    output logic [CNT_W-1:0]                         count_out,
    output logic                                     occupied
);
    import sdu_pkg::*;

    logic                entry_reg;
    logic [VALUE_W-1:0]  entry_value_reg;
    logic                entry_next;
    item_ctrl_t          ctrl_reg;
    item_ctrl_t          ctrl_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                hit;
    logic                take;

    // Compare the passing item with this cell's entry; an empty cell takes
    // the first item that no earlier cell matched or stored.
    always_comb
    begin
        hit        = entry_reg && (entry_value_reg == value_in);
        take       = !entry_reg && !ctrl_in.matched && !ctrl_in.captured;
        ctrl_next  = ctrl_in;
        count_next = count_in;
        entry_next = entry_reg;
        if (ctrl_in.valid)
        begin
            if (hit)
            begin
                ctrl_next.matched = 1'b1;
            end
            if (take)
            begin
                ctrl_next.captured = 1'b1;
            end
            if (entry_reg || take)
            begin
                count_next = count_in + CNT_W'(1);
            end
            // The end marker empties the cell once it has passed.
            if (ctrl_in.last)
            begin
                entry_next = 1'b0;
            end
            else if (take)
            begin
                entry_next = 1'b1;
            end
        end
    end

    // Control state: occupied flag and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= 1'b0;
            ctrl_reg  <= '0;
        end
        else if (advance)
        begin
            entry_reg <= entry_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    // Payload: stored value and the item moving to the next cell.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= value_in;
            count_reg <= count_next;
            if (ctrl_in.valid && take)
            begin
                entry_value_reg <= value_in;
            end
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign value_out = value_reg;
    assign count_out = count_reg;
    assign occupied  = entry_reg;

endmodule

`default_nettype wire

// File: design/streaming_distinct_union_top.sv
// ----------------------------------------------------------------------------
// streaming_distinct_union_top
// Duplicate-removing union of two sets fed as one stream of values.
// ----------------------------------------------------------------------------
// Usage: send the values of set A and then of set B on the input channel
// (value, end_of_sets; in_valid/in_ready). Each item yields one result on the
// output channel (value_out, is_new, distinct_count, overflow;
// out_valid/out_ready). Items flagged is_new, in order, form the union.
// The store is a chain of DEPTH cells, one stored value per cell. Each item
// walks the chain one cell per cycle, so a new item enters every cycle;
// both hold while the receiver stalls. Each item passes the DEPTH cells and
// then the output register. Throughput is one item per unstalled cycle.
// An item with end_of_sets set empties each cell as it passes, so items
// behind it see an empty store.
// Reset empties every cell and the output register. When the receiver
// stalls, the whole chain and the input side hold until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_distinct_union_top #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [sdu_pkg::VALUE_W-1:0] value,
    input  wire logic                              end_of_sets,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [sdu_pkg::VALUE_W-1:0]     value_out,
    output logic                                   is_new,
    output logic [sdu_pkg::OUT_CNT_W-1:0]          distinct_count,
    output logic                                   overflow
);
    import sdu_pkg::*;

    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned WIDE_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    item_ctrl_t          chain_ctrl  [DEPTH+1];
    logic [VALUE_W-1:0]  chain_value [DEPTH+1];
    logic [CNT_W-1:0]    chain_count [DEPTH+1];
    logic [DEPTH-1:0]    occupied;
    logic                advance;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_new_reg;
    logic                out_ovf_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [WIDE_W-1:0]   count_wide;

    // The chain moves when the output register is free or being emptied.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Head of the chain: the incoming item with clean flags.
    always_comb
    begin
        chain_ctrl[0].valid    = in_valid;
        chain_ctrl[0].last     = end_of_sets;
        chain_ctrl[0].matched  = 1'b0;
        chain_ctrl[0].captured = 1'b0;
        chain_value[0]         = value;
        chain_count[0]         = '0;
    end

    // Row of store cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sdu_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .ctrl_in   (chain_ctrl[i]),
            .value_in  (chain_value[i]),
            .count_in  (chain_count[i]),
            .ctrl_out  (chain_ctrl[i+1]),
            .value_out (chain_value[i+1]),
            .count_out (chain_count[i+1]),
            .occupied  (occupied[i])
        );
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_ctrl[DEPTH].valid;
        end
    end

    // Output register payload: an item that no cell matched is new; a new
    // item that no cell stored found the store full.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= chain_value[DEPTH];
            out_new_reg   <= !chain_ctrl[DEPTH].matched;
            out_ovf_reg   <= !chain_ctrl[DEPTH].matched && !chain_ctrl[DEPTH].captured;
            out_count_reg <= chain_count[DEPTH];
        end
    end

    assign count_wide     = WIDE_W'(out_count_reg);
    assign out_valid      = out_valid_reg;
    assign value_out      = out_value_reg;
    assign is_new         = out_new_reg;
    assign overflow       = out_ovf_reg;
    assign distinct_count = count_wide[OUT_CNT_W-1:0];

    // An empty cell in front of an occupied one means an end marker sits
    // between them and is still clearing its way down the chain.
    for (genvar j = 1; j < DEPTH; j++)
    begin : g_chk
        a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
            (occupied[j] && !occupied[j-1]) |->
                (chain_ctrl[j].valid && chain_ctrl[j].last))
            else $error("store cell empty ahead of an occupied cell");
    end

    // The head cell empties only after an end marker passes through it.
    a_clear_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(occupied[0]) |-> $past(advance && in_valid && end_of_sets))
        else $error("head cell cleared without an end marker");

    // An overflow result reports a completely full store.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (is_new && out_count_reg == CNT_W'(DEPTH)))
        else $error("overflow reported while the store was not full");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for streaming_distinct_union_top. A scoreboard keeps its
// own store of distinct values and predicts every result. The stimulus runs
// directed corner values first, then random sets, some long enough to fill
// the store. Both handshake sides idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------

module tb;

    localparam int unsigned DEPTH        = 256;
    localparam int unsigned HOLD_CYCLES  = 700;
    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef logic [sdu_pkg::VALUE_W-1:0] word_t;

    // One expected result item.
    typedef struct packed {
        word_t                          value;
        logic                           is_new;
        logic [sdu_pkg::OUT_CNT_W-1:0]  count;
        logic                           overflow;
    } union_result_t;

    // Tracks the distinct values seen in the current set and the results
    // still owed by the block.
    class union_scoreboard;
        word_t         seen_values [DEPTH];
        int unsigned   seen_count;
        union_result_t expected_results [$];
        int unsigned   error_count;

        function new();
            seen_count  = 0;
            error_count = 0;
        endfunction

        // Work out the result for one accepted input item.
        function void predict_item(word_t v, logic last);
            union_result_t r;
            bit            hit;
            hit = 1'b0;
            for (int unsigned i = 0; i < seen_count; i++)
            begin
                if (seen_values[i] == v)
                    hit = 1'b1;
            end
            r.value    = v;
            r.is_new   = !hit;
            r.overflow = 1'b0;
            if (!hit)
            begin
                if (seen_count < DEPTH)
                begin
                    seen_values[seen_count] = v;
                    seen_count++;
                end
                else
                begin
                    r.overflow = 1'b1;
                end
            end
            r.count = seen_count[sdu_pkg::OUT_CNT_W-1:0];
            // The end marker empties the store only after its own item.
            if (last)
                seen_count = 0;
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_val,
                                  logic [31:0] act_val);
            if (act_val !== exp_val)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_val, act_val);
                error_count++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void compare_result(word_t v, logic nw,
                                     logic [sdu_pkg::OUT_CNT_W-1:0] cnt,
                                     logic ovf);
            union_result_t r;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, v);
                error_count++;
                return;
            end
            r = expected_results.pop_front();
            check_field("value_out", r.value, v);
            check_field("is_new", 32'(r.is_new), 32'(nw));
            check_field("distinct_count", 32'(r.count), 32'(cnt));
            check_field("overflow", 32'(r.overflow), 32'(ovf));
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                                  clk         = 1'b0;
    logic                                  rst_n       = 1'b0;
    logic                                  in_valid    = 1'b0;
    logic                                  in_ready;
    logic signed [sdu_pkg::VALUE_W-1:0]    value       = '0;
    logic                                  end_of_sets = 1'b0;
    logic                                  out_valid;
    logic                                  out_ready   = 1'b0;
    logic signed [sdu_pkg::VALUE_W-1:0]    value_out;
    logic                                  is_new;
    logic [sdu_pkg::OUT_CNT_W-1:0]         distinct_count;
    logic                                  overflow;

    union_scoreboard sb;
    int unsigned     cycle_count  = 0;
    int unsigned     items_sent   = 0;
    bit              hold_req     = 0;
    bit              quiet_sender = 0;

    streaming_distinct_union_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .end_of_sets   (end_of_sets),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value_out     (value_out),
        .is_new        (is_new),
        .distinct_count(distinct_count),
        .overflow      (overflow)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Offer one item and wait until the block takes it.
    task automatic send_item(input word_t v, input logic last);
        int unsigned gap;
        gap = (hold_req || quiet_sender) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        value       <= v;
        end_of_sets <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.predict_item(v, last);
        items_sent++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One set of values: repeats from the set itself, a small pool that
    // collides often, and full-range values. Long sets repeat rarely so
    // that they overrun the store.
    task automatic send_set(input int unsigned len, input bit with_marker,
                            input bit long_set);
        word_t       history [$];
        word_t       v;
        int unsigned r;
        int unsigned rep_pct;
        int unsigned pool_pct;
        logic        last;
        rep_pct  = long_set ? 8 : 30;
        pool_pct = long_set ? 12 : 50;
        for (int unsigned i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (history.size() > 0 && r < rep_pct)
                v = history[$urandom_range(0, history.size() - 1)];
            else if (r < pool_pct)
                v = word_t'($urandom_range(0, 31)) - word_t'(16);
            else
                v = $urandom();
            history.push_back(v);
            // A stray marker inside a set now and then.
            last = (i == len - 1) ? with_marker : ($urandom_range(0, 99) == 0);
            send_item(v, last);
        end
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold-off.
    initial
    begin
        int unsigned g;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                g = pick_gap();
                if (g > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    // Check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.compare_result(value_out, is_new, distinct_count, overflow);
    end

    // Run limit.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus.
    initial
    begin
        word_t directed_values [13] = '{
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
            32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678,
            32'h1234_5678
        };
        bit directed_marks [13] = '{
            0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1
        };
        int unsigned set_idx;
        int unsigned len;
        bit          long_set;
        bit          marker;

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the value, repeats, a marker on a repeated value, a
        // new value after a clear, and a marker on a new value.
        for (int unsigned i = 0; i < 13; i++)
            send_item(directed_values[i], directed_marks[i]);

        // Random sets. The first one fills the store and runs into overflow.
        set_idx = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            long_set = (set_idx == 0) || (set_idx == 3) || ($urandom_range(0, 9) == 0);
            len      = long_set ? $urandom_range(290, 330) : $urandom_range(1, 40);
            marker   = $urandom_range(0, 19) != 0;
            quiet_sender = $urandom_range(0, 3) == 0;
            // The receiver holds off while this set streams in without gaps.
            if (set_idx == 3)
                hold_req = 1;
            if (set_idx == 6 || set_idx == 20)
                drain_results();
            send_set(len, marker, long_set);
            set_idx++;
        end

        drain_results();
        repeat (DEPTH + 20) @(posedge clk);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
